### src/rwc_pkg.sv
// ----------------------------------------------------------------------------
// rwc_pkg
// shared types and constants of the rolling weak checksum block
// ----------------------------------------------------------------------------
`default_nettype none

package rwc_pkg;

  localparam int unsigned LEN_W      = 13;
  localparam int unsigned SUM_W      = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLLING_MODE  = 1'd1;

  localparam logic [LEN_W-1:0] LEN_RESET = 13'd1024;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              restart;
    logic              stream_end;
  } in_word_t;

  typedef struct packed {
    logic [31:0] weak_sum;
    logic        short_block;
  } out_word_t;

endpackage

`default_nettype wire

### src/rwc_ring.sv
// ----------------------------------------------------------------------------
// rwc_ring
// ring store of recent bytes, one read and one write port, read data
// registered, same-cycle write to the read slot forwarded
// ----------------------------------------------------------------------------
`default_nettype none

module rwc_ring
  import rwc_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 4096,
  parameter int unsigned AW         = 12
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rd_en_i,
  input  wire logic [AW-1:0]     rd_addr_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     wr_addr_i,
  input  wire logic [BYTE_W-1:0] wr_data_i,
  output logic      [BYTE_W-1:0] rd_byte_o
);

  logic [BYTE_W-1:0] mem [MAX_WINDOW];
  logic [BYTE_W-1:0] rd_data_q;
  logic [BYTE_W-1:0] fwd_byte_q;
  logic              fwd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q  <= mem[rd_addr_i];
      fwd_byte_q <= wr_data_i;
    end
  end

  // read and write of the same slot in one cycle: take the new byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= we_i && (rd_addr_i == wr_addr_i);
    end
  end

  assign rd_byte_o = fwd_q ? fwd_byte_q : rd_data_q;

endmodule

`default_nettype wire

### src/rwc_accum.sv
// ----------------------------------------------------------------------------
// rwc_accum
// byte sum, weighted sum and fill count; forms the checksum word
// ----------------------------------------------------------------------------
`default_nettype none

module rwc_accum
  import rwc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              clear_i,
  input  wire logic [LEN_W-1:0]  len_i,
  input  wire logic              rolling_i,
  input  wire logic              proc_i,
  input  wire in_word_t          word_i,
  input  wire logic [BYTE_W-1:0] leaving_i,
  output logic                   res_valid_o,
  output out_word_t              res_o
);

  logic [LEN_W-1:0] fill_d, fill_q;
  logic [SUM_W-1:0] low_d, low_q;
  logic [SUM_W-1:0] wsum_d, wsum_q;

  logic [LEN_W-1:0]          fill0, fill1;
  logic [SUM_W-1:0]          low0, wsum0, low1, wsum1;
  logic [LEN_W+BYTE_W-1:0]   prod;
  logic                      full;

  always_comb begin
    fill0 = word_i.restart ? '0 : fill_q;
    low0  = word_i.restart ? '0 : low_q;
    wsum0 = word_i.restart ? '0 : wsum_q;
    prod  = len_i * leaving_i;
    full  = rolling_i && (fill0 >= len_i);

    if (full) begin
      low1  = low0 - SUM_W'(leaving_i) + SUM_W'(word_i.data_byte);
      wsum1 = wsum0 - prod[SUM_W-1:0] + low1;
      fill1 = len_i;
    end else begin
      low1  = low0 + SUM_W'(word_i.data_byte);
      wsum1 = wsum0 + low1;
      fill1 = fill0 + 1'b1;
    end

    res_valid_o       = (fill1 >= len_i) || (!rolling_i && word_i.stream_end);
    res_o.weak_sum    = {wsum1, low1};
    res_o.short_block = !rolling_i && (fill1 < len_i);

    fill_d = fill_q;
    low_d  = low_q;
    wsum_d = wsum_q;
    if (clear_i) begin
      fill_d = '0;
      low_d  = '0;
      wsum_d = '0;
    end else if (proc_i) begin
      if (word_i.stream_end || (!rolling_i && res_valid_o)) begin
        fill_d = '0;
        low_d  = '0;
        wsum_d = '0;
      end else begin
        fill_d = fill1;
        low_d  = low1;
        wsum_d = wsum1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      low_q  <= '0;
      wsum_q <= '0;
    end else begin
      fill_q <= fill_d;
      low_q  <= low_d;
      wsum_q <= wsum_d;
    end
  end

endmodule

`default_nettype wire

### src/rolling_weak_checksum.sv
// ----------------------------------------------------------------------------
// rolling_weak_checksum
// rsync style 32-bit weak checksum over a byte stream, block or sliding mode
// ----------------------------------------------------------------------------
//  port group   direction  handshake          word
//  in           in         in_valid_i/stall   in_word_t (byte, restart, end)
//  out          out        out_valid_o/stall  out_word_t (weak_sum, short)
//  cfg          in         cfg_we_i           cfg_idx_i, cfg_wdata_i
//
//  one word per clock when the output does not stall; a taken word is
//  registered in stage 1 (ring read), then its sums in the output register
//  the rate is set by the sum update loop, one word per unstalled clock
//  reset clears control state and sums; the ring store is not cleared, a
//  slot is only used after it was written
//  an output stall holds the update stage, the input stalls once it is full
// ----------------------------------------------------------------------------
`default_nettype none

module rolling_weak_checksum
  import rwc_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 4096
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_word_t              in_word_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_word_t                  out_word_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW = $clog2(MAX_WINDOW);

  // configuration
  logic [LEN_W-1:0] len_q;
  logic             rolling_q;
  logic [LEN_W-1:0] eff_len;

  // stage 1: ring read data valid here, sums update here
  logic          s1_valid_q;
  in_word_t      s1_word_q;
  logic [AW-1:0] s1_wp_q;

  // ring write pointer, advanced when a word is taken in rolling mode
  logic [AW-1:0] wp_q;

  logic          out_valid_q;
  out_word_t     out_word_q;

  logic          out_free, s1_free, accept, proc;
  logic [31:0]   diff;
  logic [AW-1:0] rd_addr;
  logic [BYTE_W-1:0] leaving;
  logic          res_valid;
  out_word_t     res;

  // length clamp: zero acts as one, above the ring depth acts as the depth
  always_comb begin
    if (len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(len_q) > 32'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = len_q;
    end
  end

  // slot of the byte leaving the window, wraps at the ring depth
  always_comb begin
    diff = 32'(wp_q) - 32'(eff_len);
    if (diff[31]) begin
      diff = diff + 32'(MAX_WINDOW);
    end
    rd_addr = diff[AW-1:0];
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_free    = !s1_valid_q || out_free;
  assign accept     = in_valid_i && s1_free;
  assign proc       = s1_valid_q && out_free;
  assign in_stall_o = !s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= LEN_RESET;
      rolling_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW_LENGTH: len_q     <= cfg_wdata_i[LEN_W-1:0];
        CFG_ROLLING_MODE:  rolling_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      wp_q       <= '0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= accept;
      end
      if (accept && rolling_q) begin
        wp_q <= (32'(wp_q) == MAX_WINDOW - 1) ? '0 : wp_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_word_q <= in_word_i;
      s1_wp_q   <= wp_q;
    end
  end

  rwc_ring #(
    .MAX_WINDOW(MAX_WINDOW),
    .AW        (AW)
  ) u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_addr_i(rd_addr),
    .we_i     (proc && rolling_q),
    .wr_addr_i(s1_wp_q),
    .wr_data_i(s1_word_q.data_byte),
    .rd_byte_o(leaving)
  );

  rwc_accum u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (cfg_we_i),
    .len_i      (eff_len),
    .rolling_i  (rolling_q),
    .proc_i     (proc),
    .word_i     (s1_word_q),
    .leaving_i  (leaving),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= proc && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && proc && res_valid) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire
